>>> rtl/matrix4_arith_unit_macros.svh
// Assertion macros for the 4x4 matrix arithmetic unit.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef MATRIX4_ARITH_UNIT_MACROS_SVH
`define MATRIX4_ARITH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M4AU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define M4AU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/m4au_pkg.sv
// Shared types and constants of the 4x4 matrix arithmetic unit.
// Used by every module of the unit; depends on nothing else.
`default_nettype none

package m4au_pkg;

	localparam int ELEM_W         = 32;
	localparam int IDX_W          = 4;
	localparam int ELEMS          = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Operation codes, taken from the first word of a matrix.
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_SUB    = 3'd1;
	localparam logic [2:0] OP_MATMUL = 3'd2;
	localparam logic [2:0] OP_ADDS   = 3'd3;
	localparam logic [2:0] OP_SUBS   = 3'd4;
	localparam logic [2:0] OP_MULS   = 3'd5;
	localparam logic [2:0] OP_DIVS   = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [ELEM_W-1:0] left_elem;
		logic signed [ELEM_W-1:0] right_elem;
	} item_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] result_elem;
		logic [IDX_W-1:0]         elem_index;
		logic [1:0]               status;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_clr;
	} mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/m4au_store.sv
// Operand memories of the matrix unit: one for the left and one for the right matrix.
// Depends on m4au_pkg for the depth and the address width.
`default_nettype none

module m4au_store #(
	parameter int EW = m4au_pkg::DATA_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           we,
	input  wire logic [m4au_pkg::IDX_W-1:0] waddr,
	input  wire logic [EW-1:0]            wleft,
	input  wire logic [EW-1:0]            wright,
	input  wire logic [m4au_pkg::IDX_W-1:0] raddr_l,
	input  wire logic [m4au_pkg::IDX_W-1:0] raddr_r,
	output logic [EW-1:0]                 rdata_l,
	output logic [EW-1:0]                 rdata_r
);

	logic [EW-1:0] left_mem  [m4au_pkg::ELEMS];
	logic [EW-1:0] right_mem [m4au_pkg::ELEMS];

	always_ff @(posedge clk) begin
		if (we) begin
			left_mem[waddr]  <= wleft;
			right_mem[waddr] <= wright;
		end
		rdata_l <= left_mem[raddr_l];
		rdata_r <= right_mem[raddr_r];
	end

endmodule

`default_nettype wire

>>> rtl/m4au_mac.sv
// Shared multiplier with a registered product and an accumulator behind it.
// Depends on m4au_pkg for the control structure.
`default_nettype none

module m4au_mac #(
	parameter int EW    = m4au_pkg::DATA_WIDTH_DEF,
	parameter int ACC_W = 2 * m4au_pkg::DATA_WIDTH_DEF + 2
) (
	input  wire                         clk,
	input  wire m4au_pkg::mac_ctrl_t    ctrl,
	input  wire logic signed [EW-1:0]   a,
	input  wire logic signed [EW-1:0]   b,
	output logic signed [2*EW-1:0]      prod,
	output logic signed [ACC_W-1:0]     acc
);

	localparam int PW = 2 * EW;

	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q, prod_ext;

	assign prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= a * b;
		end
		if (ctrl.acc_en) begin
			acc_q <= (ctrl.acc_clr ? '0 : acc_q) + prod_ext;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

>>> rtl/m4au_div.sv
// Restoring divider, one quotient bit a cycle, for the divide-by-scalar operation.
// Computes (a * 2^FB) / s truncated toward zero; depends on m4au_pkg for its parameter defaults.
`default_nettype none

module m4au_div #(
	parameter int EW = m4au_pkg::DATA_WIDTH_DEF,
	parameter int FB = m4au_pkg::FRAC_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire logic signed [EW-1:0] dividend,
	input  wire logic signed [EW-1:0] divisor,
	output logic                      done,
	output logic signed [EW+FB:0]     quot
);

	localparam int NW = EW + FB;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [EW-1:0] rem_q, den_q;
	logic          neg_q, busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [EW-1:0] mag_a, mag_b;
	logic [EW:0]   rem_sh, diff;
	logic          qbit;

	// Magnitudes; the most negative value maps onto its own bit pattern, which is right.
	assign mag_a = dividend[EW-1] ? EW'(-dividend) : dividend;
	assign mag_b = divisor[EW-1]  ? EW'(-divisor)  : divisor;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign qbit   = !diff[EW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(mag_a) << FB;
			rem_q <= '0;
			den_q <= mag_b;
			neg_q <= dividend[EW-1] ^ divisor[EW-1];
		end else if (busy_q) begin
			rem_q <= qbit ? diff[EW-1:0] : rem_sh[EW-1:0];
			num_q <= {num_q[NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

`default_nettype wire

>>> rtl/matrix4_arith_unit.sv
// Top level of the 4x4 matrix arithmetic unit in signed fixed point.
// Depends on m4au_pkg, m4au_store, m4au_mac, m4au_div and the assertion macro header.
//
// Usage. A matrix job is sixteen input words in row-major order on the item channel
// (item, item_valid, item_stall). Each word carries one element of the left matrix and
// the matching element of the right matrix; on the first word the right field is the
// scalar for the scalar operations, and the opcode is taken from that word alone.
// Loading takes one cycle per word. After the sixteenth word the unit raises item_stall
// and works through the sixteen results one by one, handing each to a single output
// register on the result channel (result, result_valid, result_stall).
// Steps per result element, all set by the sequencer around the one shared multiplier,
// adder and divider: read, operate and finish for the elementwise and scalar add,
// subtract and multiply; four read, multiply, accumulate rounds on the memory ports,
// then finish, for the matrix product; and read, start the divider unless the scalar
// is zero, wait on it and finish for the scalar divide, on the one-bit-per-cycle divider.
// A stalled result word holds; the sequencer waits for the output register to empty
// before it hands over the next element. Loading of the next job may start while the
// last result word still waits. Reset empties the output register and returns the unit
// to loading at element zero; the operand memories are not cleared.
`default_nettype none

`include "matrix4_arith_unit_macros.svh"

module matrix4_arith_unit #(
	parameter int FRAC_BITS  = m4au_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = m4au_pkg::DATA_WIDTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire m4au_pkg::item_t     item,
	input  wire                      item_valid,
	output logic                     item_stall,
	output m4au_pkg::result_t        result,
	output logic                     result_valid,
	input  wire                      result_stall
);

	// Element width actually used: operands are the low EW bits of each field.
	localparam int EW    = (DATA_WIDTH > m4au_pkg::ELEM_W) ? m4au_pkg::ELEM_W : DATA_WIDTH;
	localparam int NW    = EW + FRAC_BITS;
	localparam int PW    = 2 * EW;
	// Wide enough for four summed products and for the divider quotient.
	localparam int ACC_W = (PW + 2 > NW + 2) ? PW + 2 : NW + 2;
	localparam int IW    = m4au_pkg::IDX_W;

	localparam logic [IW-1:0] LAST_IDX = IW'(m4au_pkg::ELEMS - 1);
	localparam logic [1:0]    LAST_K   = 2'd3;

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-EW+1){1'b1}}, {(EW-1){1'b0}}};

	// Sequencer states.
	localparam logic [2:0] S_LOAD = 3'd0;  // taking words into the memories
	localparam logic [2:0] S_RD   = 3'd1;  // memory read address presented
	localparam logic [2:0] S_OPND = 3'd2;  // operands out of memory, multiply, add or start the divider
	localparam logic [2:0] S_ACC  = 3'd3;  // accumulate one product of a dot product
	localparam logic [2:0] S_DIV  = 3'd4;  // waiting on the divider
	localparam logic [2:0] S_FIN  = 3'd5;  // saturate and hand over to the output

	logic [2:0]           state_q;
	logic [IW-1:0]        pos_q, elem_q;
	logic [1:0]           k_q;
	logic [2:0]           op_q;
	logic signed [EW-1:0] scalar_q;
	logic signed [EW:0]   sum_q, sum_d, a_ext, b_ext;
	logic                 out_valid_q;
	m4au_pkg::result_t    result_q;

	logic                 item_acc, out_free, fin_load, is_mm, dz, div_start, div_done;
	logic [IW-1:0]        raddr_l, raddr_r;
	logic [EW-1:0]        rdata_l, rdata_r;
	logic signed [EW-1:0] opnd_a, opnd_b;
	m4au_pkg::mac_ctrl_t  mac_ctrl;
	logic signed [PW-1:0] prod;
	logic signed [ACC_W-1:0] acc, prod_ext, quot_ext, sum_ext, pre_w, fin_w;
	logic signed [NW:0]   quot;
	logic [1:0]           fin_st;

	assign item_acc   = item_valid && !item_stall;
	assign item_stall = (state_q != S_LOAD);
	assign out_free   = !out_valid_q || !result_stall;
	assign fin_load   = (state_q == S_FIN) && out_free;
	assign is_mm      = (op_q == m4au_pkg::OP_MATMUL);
	assign dz         = (scalar_q == '0);

	// A dot product walks row elem/4 of the left matrix and column elem%4 of the right.
	assign raddr_l = is_mm ? {elem_q[3:2], k_q} : elem_q;
	assign raddr_r = is_mm ? {k_q, elem_q[1:0]} : elem_q;

	m4au_store #(
		.EW(EW)
	) u_store (
		.clk     (clk),
		.we      (item_acc),
		.waddr   (pos_q),
		.wleft   (item.left_elem[EW-1:0]),
		.wright  (item.right_elem[EW-1:0]),
		.raddr_l (raddr_l),
		.raddr_r (raddr_r),
		.rdata_l (rdata_l),
		.rdata_r (rdata_r)
	);

	assign opnd_a = rdata_l;

	always_comb begin
		if (op_q inside {m4au_pkg::OP_ADD, m4au_pkg::OP_SUB, m4au_pkg::OP_MATMUL}) begin
			opnd_b = rdata_r;
		end else begin
			opnd_b = scalar_q;
		end
	end

	assign mac_ctrl.mul_en  = (state_q == S_OPND);
	assign mac_ctrl.acc_en  = (state_q == S_ACC);
	assign mac_ctrl.acc_clr = (k_q == '0);

	m4au_mac #(
		.EW    (EW),
		.ACC_W (ACC_W)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.a    (opnd_a),
		.b    (opnd_b),
		.prod (prod),
		.acc  (acc)
	);

	assign div_start = (state_q == S_OPND) && (op_q == m4au_pkg::OP_DIVS) && !dz;

	m4au_div #(
		.EW (EW),
		.FB (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (opnd_a),
		.divisor  (scalar_q),
		.done     (div_done),
		.quot     (quot)
	);

	// Elementwise and scalar add and subtract; for other operations the left operand passes through,
	// which also keeps the dividend's sign for the divide-by-zero case.
	assign a_ext = {opnd_a[EW-1], opnd_a};
	assign b_ext = {opnd_b[EW-1], opnd_b};

	always_comb begin
		case (op_q)
			m4au_pkg::OP_ADD, m4au_pkg::OP_ADDS: sum_d = a_ext + b_ext;
			m4au_pkg::OP_SUB, m4au_pkg::OP_SUBS: sum_d = a_ext - b_ext;
			default:                             sum_d = a_ext;
		endcase
	end

	assign prod_ext = {{(ACC_W-PW){prod[PW-1]}}, prod};
	assign quot_ext = {{(ACC_W-NW-1){quot[NW]}}, quot};
	assign sum_ext  = {{(ACC_W-EW-1){sum_q[EW]}}, sum_q};

	// Value before saturation. Products are shifted with floor rounding.
	always_comb begin
		case (op_q)
			m4au_pkg::OP_MATMUL: pre_w = acc >>> FRAC_BITS;
			m4au_pkg::OP_MULS:   pre_w = prod_ext >>> FRAC_BITS;
			m4au_pkg::OP_DIVS:   pre_w = dz ? (sum_q[EW] ? SAT_LO : SAT_HI) : quot_ext;
			default:             pre_w = sum_ext;
		endcase
	end

	always_comb begin
		if (pre_w > SAT_HI) begin
			fin_w  = SAT_HI;
			fin_st = m4au_pkg::ST_SAT;
		end else if (pre_w < SAT_LO) begin
			fin_w  = SAT_LO;
			fin_st = m4au_pkg::ST_SAT;
		end else begin
			fin_w  = pre_w;
			fin_st = m4au_pkg::ST_OK;
		end
		if ((op_q == m4au_pkg::OP_DIVS) && dz) begin
			fin_st = m4au_pkg::ST_DZ;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			pos_q       <= '0;
			elem_q      <= '0;
			k_q         <= '0;
			op_q        <= m4au_pkg::OP_ADD;
			scalar_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_LOAD: begin
					if (item_acc) begin
						if (pos_q == '0) begin
							op_q     <= item.opcode;
							scalar_q <= item.right_elem[EW-1:0];
						end
						if (pos_q == LAST_IDX) begin
							pos_q   <= '0;
							elem_q  <= '0;
							k_q     <= '0;
							state_q <= S_RD;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_OPND;
				end
				S_OPND: begin
					if (is_mm) begin
						state_q <= S_ACC;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ACC: begin
					if (k_q == LAST_K) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						k_q     <= '0;
						elem_q  <= elem_q + 1'b1;
						state_q <= (elem_q == LAST_IDX) ? S_LOAD : S_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_OPND) begin
			sum_q <= sum_d;
		end
		if (fin_load) begin
			result_q.result_elem <= fin_w[m4au_pkg::ELEM_W-1:0];
			result_q.elem_index  <= elem_q;
			result_q.status      <= fin_st;
			result_q.last        <= (elem_q == LAST_IDX);
		end
	end

	assign result       = result_q;
	assign result_valid = out_valid_q;

	// The load count must be back at zero whenever the sequencer is computing.
	`M4AU_ASSERT_IMP(a_pos_clear, state_q != S_LOAD, pos_q == '0, "load count not clear")
	// The divider only finishes while the sequencer waits for it.
	`M4AU_ASSERT_IMP(a_div_owned, div_done, state_q == S_DIV, "divider done out of turn")
	// The sixteenth word starts the computation on the next cycle.
	`M4AU_ASSERT_NXT(a_load_done, item_acc && pos_q == LAST_IDX, state_q == S_RD, "no compute start")

endmodule

`default_nettype wire
